// ===== sv/dstwr_pkg.sv =====
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared constants, widths and types of the two-way ranging core.
// ----------------------------------------------------------------------------
package dstwr_pkg;

  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  // running sum, sum of squares, gate difference and compare widths
  localparam int SUM_W  = 22 + HIST_AW;
  localparam int SQ_W   = 42 + HIST_AW;
  localparam int DIFF_W = SUM_W + HIST_AW + 1;
  localparam int CMP_W  = 66 + 2 * HIST_AW;

  localparam int OUTLIER_FACTOR = 4;
  localparam int DIST_W   = 21;
  localparam int DIV_STEPS = 23;
  localparam int DIV_CW    = 5;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 21'sd1048575;
  localparam logic signed [DIST_W-1:0] DIST_MIN = -21'sd1048576;

  localparam logic [15:0] ANT_DELAY_RST  = 16'd0;
  localparam logic [23:0] TICK_SCALE_RST = 24'd307479;

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_ANT_DELAY  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TICK_SCALE = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MULA, ST_MULB, ST_MAG, ST_SCLO, ST_SCHI, ST_SUM, ST_DIV,
    ST_ROUND, ST_DIFF, ST_MULE, ST_MULS, ST_MULD, ST_MULO, ST_GATE, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPT, OP_MULA, OP_MULB, OP_MAG, OP_SCLO, OP_SCHI, OP_SUM,
    OP_DIV, OP_ROUND, OP_DIFF, OP_MULE, OP_MULS, OP_MULD, OP_MULO, OP_GATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic out_ready;
  } dp_stat_t;

endpackage

// ===== sv/dstwr_if.sv =====
// ----------------------------------------------------------------------------
// dstwr channel interfaces
// Valid/ready channels for exchange words, result words and register writes.
// ----------------------------------------------------------------------------
interface dstwr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] poll_sent;
  logic [31:0] answer_seen;
  logic [31:0] final_sent;
  logic [31:0] poll_seen_remote;
  logic [31:0] answer_sent_remote;
  logic [31:0] final_seen_remote;
  modport source (output valid, poll_sent, answer_seen, final_sent, poll_seen_remote,
                  answer_sent_remote, final_seen_remote, input ready);
  modport sink (input valid, poll_sent, answer_seen, final_sent, poll_seen_remote,
                answer_sent_remote, final_seen_remote, output ready);
endinterface

interface dstwr_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] distance_mm;
  logic               accepted;
  logic signed [20:0] filtered_mm;
  modport source (output valid, distance_mm, accepted, filtered_mm, input ready);
  modport sink (input valid, distance_mm, accepted, filtered_mm, output ready);
endinterface

interface dstwr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dstwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dstwr_ctrl
// Sequencer that steps the datapath through one ranging exchange.
// ----------------------------------------------------------------------------
module dstwr_ctrl
  import dstwr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t             state_r, state_nxt;
  logic [DIV_CW-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.emit  = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPT;
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin cmd.op = OP_MULA; state_nxt = ST_MULB; end
      ST_MULB: begin cmd.op = OP_MULB; state_nxt = ST_MAG;  end
      ST_MAG:  begin cmd.op = OP_MAG;  state_nxt = ST_SCLO; end
      ST_SCLO: begin cmd.op = OP_SCLO; state_nxt = ST_SCHI; end
      ST_SCHI: begin cmd.op = OP_SCHI; state_nxt = ST_SUM;  end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin cmd.op = OP_ROUND; state_nxt = ST_DIFF; end
      ST_DIFF:  begin cmd.op = OP_DIFF;  state_nxt = ST_MULE; end
      ST_MULE:  begin cmd.op = OP_MULE;  state_nxt = ST_MULS; end
      ST_MULS:  begin cmd.op = OP_MULS;  state_nxt = ST_MULD; end
      ST_MULD:  begin cmd.op = OP_MULD;  state_nxt = ST_MULO; end
      ST_MULO:  begin cmd.op = OP_MULO;  state_nxt = ST_GATE; end
      ST_GATE:  begin cmd.op = OP_GATE;  state_nxt = ST_DONE; end
      ST_DONE: begin
        // hand the word over once the output register frees up
        if (!stat.out_full || stat.out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/dstwr_dp.sv =====
// ----------------------------------------------------------------------------
// dstwr_dp
// Interval, shared multiplier, serial divider, history and outlier gate.
// ----------------------------------------------------------------------------
module dstwr_dp
  import dstwr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [31:0]              poll_sent,
  input  logic [31:0]              answer_seen,
  input  logic [31:0]              final_sent,
  input  logic [31:0]              poll_seen_remote,
  input  logic [31:0]              answer_sent_remote,
  input  logic [31:0]              final_seen_remote,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [23:0]              cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DIST_W-1:0] distance_mm,
  output logic                     accepted,
  output logic signed [DIST_W-1:0] filtered_mm
);

  logic [15:0] ant_r;
  logic [23:0] ts_r;

  logic [31:0] r1_r, r2_r, p1_r, p2_r;
  logic [33:0] den_r;
  logic [63:0] pa_r, pb_r, mag_r;
  logic        neg_r;
  logic [55:0] plo_r, phi_r;
  logic        sat_r;
  logic [49:0] rem_r;
  logic [DIV_STEPS-1:0] nb_r, q_r;
  logic signed [DIST_W-1:0] d_r, old_r, held_r;
  logic [31:0] e_r, da_r;
  logic [63:0] e2_r, s2_r, d2_r, o2_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic [HIST_AW-1:0]      ptr_r, nptr;
  logic [HIST_DEPTH-1:0]   vld_r;
  logic signed [DIST_W-1:0] hist [HIST_DEPTH];
  logic                    acc_r;
  logic                    ov_r;
  logic signed [DIST_W-1:0] od_r, of_r;
  logic                    oa_r;

  // corrected local times and the four intervals
  logic [31:0] half, ptx, arx, ftx;
  assign half = {17'd0, ant_r[15:1]};
  assign ptx  = poll_sent + half;
  assign arx  = answer_seen - half;
  assign ftx  = final_sent + half;

  assign nptr = (ptr_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  always_comb begin
    case (cmd.op)
      OP_MULA: begin ma = r1_r;         mb = r2_r;           end
      OP_MULB: begin ma = p1_r;         mb = p2_r;           end
      OP_SCLO: begin ma = mag_r[31:0];  mb = {8'd0, ts_r};   end
      OP_SCHI: begin ma = mag_r[63:32]; mb = {8'd0, ts_r};   end
      OP_MULE: begin ma = e_r;          mb = e_r;            end
      OP_MULS: begin
        ma = sum_r[SUM_W-1] ? 32'(-sum_r) : 32'(sum_r);
        mb = ma;
      end
      OP_MULD: begin ma = da_r;         mb = da_r;           end
      OP_MULO: begin
        ma = old_r[DIST_W-1] ? 32'(-old_r) : 32'(old_r);
        mb = ma;
      end
      default: begin ma = '0;           mb = '0;             end
    endcase
  end
  assign mp = ma * mb;

  // scaled product and division step
  logic [87:0] prod;
  assign prod = {phi_r, 32'd0} + {32'd0, plo_r};
  logic [48:0] dd;
  assign dd = {den_r, 15'd0};
  logic [50:0] trial;
  assign trial = {rem_r, nb_r[DIV_STEPS-1]};
  logic        take;
  assign take = trial >= {2'b00, dd};

  // rounding to millimetres
  logic [23:0] q1;
  logic [22:0] mm;
  assign q1 = {1'b0, q_r} + 24'd1;
  assign mm = sat_r ? 23'(int'(DIST_MAX) + 2) : q1[23:1];

  // outlier gate on squares
  logic signed [DIFF_W-1:0] diff;
  assign diff = DIFF_W'(sum_r) - DIFF_W'(d_r) * DIFF_W'(HIST_DEPTH);
  logic [CMP_W-1:0] lhs, var_w, rhs;
  assign lhs   = CMP_W'(e2_r) * CMP_W'(HIST_DEPTH - 1);
  assign var_w = CMP_W'(sq_r) * CMP_W'(HIST_DEPTH) - CMP_W'(s2_r);
  assign rhs   = var_w * CMP_W'(OUTLIER_FACTOR * OUTLIER_FACTOR * HIST_DEPTH);
  logic ok;
  assign ok = lhs < rhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ant_r  <= ANT_DELAY_RST;
      ts_r   <= TICK_SCALE_RST;
      sum_r  <= '0;
      sq_r   <= '0;
      ptr_r  <= '0;
      vld_r  <= '0;
      held_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ANT_DELAY) ant_r <= cfg_data[15:0];
        else if (cfg_index == REG_TICK_SCALE) ts_r <= cfg_data;
      end
      if (cmd.op == OP_GATE) begin
        sum_r <= sum_r + SUM_W'(d_r) - SUM_W'(old_r);
        sq_r  <= sq_r + SQ_W'(d2_r) - SQ_W'(o2_r);
        ptr_r <= nptr;
        vld_r[nptr] <= 1'b1;
        if (ok) held_r <= d_r;
      end
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPT: begin
        r1_r  <= arx - ptx;
        p1_r  <= answer_sent_remote - poll_seen_remote;
        r2_r  <= final_seen_remote - answer_sent_remote;
        p2_r  <= ftx - arx;
        old_r <= vld_r[nptr] ? hist[nptr] : '0;
      end
      OP_MULA: begin
        pa_r  <= mp;
        den_r <= 34'(r1_r) + 34'(r2_r) + 34'(p1_r) + 34'(p2_r);
      end
      OP_MULB: pb_r <= mp;
      OP_MAG: begin
        neg_r <= pa_r < pb_r;
        mag_r <= (pa_r < pb_r) ? pb_r - pa_r : pa_r - pb_r;
      end
      OP_SCLO: plo_r <= mp[55:0];
      OP_SCHI: phi_r <= mp[55:0];
      OP_SUM: begin
        sat_r <= prod[87:38] >= {16'd0, den_r};
        rem_r <= prod[72:23];
        nb_r  <= prod[22:0];
        q_r   <= '0;
      end
      OP_DIV: begin
        rem_r <= take ? 50'(trial - {2'b00, dd}) : trial[49:0];
        nb_r  <= {nb_r[DIV_STEPS-2:0], 1'b0};
        q_r   <= {q_r[DIV_STEPS-2:0], take};
      end
      OP_ROUND: begin
        if (den_r == '0) d_r <= '0;
        else if (neg_r) d_r <= (mm > 23'(int'(DIST_MAX) + 1)) ? DIST_MIN : 21'sd0 - mm[20:0];
        else d_r <= (mm > 23'(int'(DIST_MAX))) ? DIST_MAX : mm[20:0];
      end
      OP_DIFF: begin
        e_r  <= diff[DIFF_W-1] ? 32'(-diff) : 32'(diff);
        da_r <= d_r[DIST_W-1] ? 32'(-d_r) : 32'(d_r);
      end
      OP_MULE: e2_r <= mp;
      OP_MULS: s2_r <= mp;
      OP_MULD: d2_r <= mp;
      OP_MULO: o2_r <= mp;
      OP_GATE: begin
        hist[nptr] <= d_r;
        acc_r      <= ok;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      od_r <= d_r;
      oa_r <= acc_r;
      of_r <= held_r;
    end
  end

  assign stat.out_full  = ov_r;
  assign stat.out_ready = out_ready;
  assign out_valid   = ov_r;
  assign distance_mm = od_r;
  assign accepted    = oa_r;
  assign filtered_mm = of_r;

endmodule

// ===== sv/ds_twr_range_with_outlier_gate_core.sv =====
// ----------------------------------------------------------------------------
// ds_twr_range_with_outlier_gate_core
// Double-sided two-way ranging distance with an outlier gate on history.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  takes one word per finished exchange: six 32-bit timestamps.
//  out_ch gives one word per input word: distance_mm, accepted, filtered_mm.
//  cfg_ch writes antenna_delay (index 0) and tick_scale (index 1); it is
//  always ready; the user must write it only while the core is idle, as the core has no check.
// Timing: an input word is taken when the core is idle. Each word passes
//  through the 23-step serial divider and the one shared 32x32 multiplier
//  (eight products per word) before a new word can be taken. A new word is
//  accepted the cycle after the result moves into the output register.
// Stall: the result waits in the output register while out_ch.ready is low;
//  the next word is still taken and processed, and its result holds in the
//  datapath until the output register is free.
// Reset: synchronous, active low; clears the history (valid bits), the
//  running sums, pointer, held distance and restores register defaults.
// ----------------------------------------------------------------------------
module ds_twr_range_with_outlier_gate_core
  import dstwr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  dstwr_in_if.sink    in_ch,
  dstwr_out_if.source out_ch,
  dstwr_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  dstwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dstwr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .poll_sent          (in_ch.poll_sent),
    .answer_seen        (in_ch.answer_seen),
    .final_sent         (in_ch.final_sent),
    .poll_seen_remote   (in_ch.poll_seen_remote),
    .answer_sent_remote (in_ch.answer_sent_remote),
    .final_seen_remote  (in_ch.final_seen_remote),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .distance_mm        (out_ch.distance_mm),
    .accepted           (out_ch.accepted),
    .filtered_mm        (out_ch.filtered_mm)
  );

endmodule

// ===== sv/dstwr_chk.sv =====
// ----------------------------------------------------------------------------
// dstwr_chk
// Port-level checks of the ranging core, bound to the top level.
// ----------------------------------------------------------------------------
module dstwr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [20:0] out_distance,
  input logic [20:0] out_filtered
);

  // hold a word until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped before taken");

  // an accepted distance becomes the filtered distance
  a_acc_filt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_filtered == out_distance)
    else $error("filtered distance differs from accepted distance");

  // the core is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result right after taking a word unless one was already waiting
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind ds_twr_range_with_outlier_gate_core dstwr_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_accepted (out_ch.accepted),
  .out_distance (out_ch.distance_mm),
  .out_filtered (out_ch.filtered_mm)
);
